>>> src/fva_pkg.sv
// ----------------------------------------------------------------------------
// fva_pkg: shared types, constants and float helpers
// Request and response structs, operation codes and the binary32 unpack,
// leading-zero count and round-and-pack functions used by the units.
// ----------------------------------------------------------------------------
`default_nettype none

package fva_pkg;

  typedef enum logic [4:0] {
    OP_MULF   = 5'd0,
    OP_DOT    = 5'd1,
    OP_FV     = 5'd2,
    OP_VF     = 5'd3,
    OP_DIVF   = 5'd4,
    OP_ADDF   = 5'd5,
    OP_ADDV   = 5'd6,
    OP_SUBF   = 5'd7,
    OP_SUBV   = 5'd8,
    OP_EQF    = 5'd9,
    OP_EQV    = 5'd10,
    OP_EQBITS = 5'd11,
    OP_NEF    = 5'd12,
    OP_NEV    = 5'd13,
    OP_NEBITS = 5'd14,
    OP_LE     = 5'd15,
    OP_GE     = 5'd16,
    OP_LT     = 5'd17,
    OP_GT     = 5'd18,
    OP_NOTF   = 5'd19,
    OP_NOTV   = 5'd20,
    OP_AND    = 5'd21,
    OP_OR     = 5'd22,
    OP_BITAND = 5'd23,
    OP_BITOR  = 5'd24
  } op_e;

  localparam logic [31:0] ONE_BITS  = 32'h3F80_0000;
  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;

  localparam int PIPE_DEPTH    = 12;
  localparam int DIV_PER_STAGE = 3;
  localparam int DIV_STAGES    = 9;

  typedef struct packed {
    logic [4:0]  req_type;
    logic [31:0] a_x;
    logic [31:0] a_y;
    logic [31:0] a_z;
    logic [31:0] b_x;
    logic [31:0] b_y;
    logic [31:0] b_z;
  } req_t;

  typedef struct packed {
    logic [31:0] r_x;
    logic [31:0] r_y;
    logic [31:0] r_z;
  } rsp_t;

  // Operand with subnormals normalized so that man[23] is set unless zero.
  typedef struct packed {
    logic               sign;
    logic signed [9:0]  exp;
    logic [23:0]        man;
    logic               nan;
    logic               inf;
    logic               zero;
  } unp_t;

  function automatic logic [5:0] lzc32(input logic [31:0] x);
    logic [5:0] n;
    n = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (x[i]) begin
        n = 6'(31 - i);
      end
    end
    return n;
  endfunction

  function automatic unp_t unpack(input logic [31:0] b);
    unp_t       u;
    logic [5:0] lz;
    u.sign = b[31];
    u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'h0);
    u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'h0);
    u.zero = (b[30:0] == 31'h0);
    lz     = lzc32({b[22:0], 9'h0});
    if (b[30:23] == 8'h00) begin
      u.man = 24'({1'b0, b[22:0]} << (lz + 6'd1));
      u.exp = -$signed({4'b0000, lz});
    end else begin
      u.man = {1'b1, b[22:0]};
      u.exp = $signed({2'b00, b[30:23]});
    end
    return u;
  endfunction

  // sig[26] is the leading one, sig[2:0] are guard, round and sticky.
  // Handles overflow to infinity, gradual underflow and round to nearest even.
  function automatic logic [31:0] round_pack(input logic sign,
                                             input logic signed [9:0] exp,
                                             input logic [26:0] sig);
    logic [26:0] s;
    logic [26:0] mask;
    logic [9:0]  sh;
    logic [7:0]  ef;
    logic        inc;
    logic [30:0] body;
    logic [31:0] r;
    s    = sig;
    ef   = exp[7:0];
    mask = '0;
    sh   = '0;
    if (exp >= 10'sd255) begin
      r = {sign, 8'hFF, 23'h0};
    end else begin
      if (exp <= 10'sd0) begin
        sh = 10'(10'sd1 - exp);
        ef = 8'h00;
        if (sh >= 10'd27) begin
          s = {26'h0, |sig};
        end else begin
          mask = (27'd1 << sh[4:0]) - 27'd1;
          s    = sig >> sh[4:0];
          s[0] = s[0] | (|(sig & mask));
        end
      end
      inc  = s[2] & (s[3] | s[1] | s[0]);
      body = {ef, s[25:3]} + {30'h0, inc};
      r    = {sign, body};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> src/fva_mul.sv
// ----------------------------------------------------------------------------
// fva_mul: three-stage binary32 multiplier
// Unpack and normalize, 24x24 product, then normalize and round.
// ----------------------------------------------------------------------------
`default_nettype none

module fva_mul
  import fva_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [31:0]      r_o
);

  unp_t              ua_q, ub_q;
  logic              sign_q, nan_q, inf_q, zero_q;
  logic signed [9:0] exp_q;
  logic [47:0]       prod_q;
  logic [31:0]       r_q, r_d;
  logic [26:0]       sig;
  logic signed [9:0] exp_n;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q   <= unpack(a_i);
      ub_q   <= unpack(b_i);
      sign_q <= ua_q.sign ^ ub_q.sign;
      nan_q  <= ua_q.nan | ub_q.nan | (ua_q.inf & ub_q.zero) | (ua_q.zero & ub_q.inf);
      inf_q  <= ua_q.inf | ub_q.inf;
      zero_q <= ua_q.zero | ub_q.zero;
      exp_q  <= ua_q.exp + ub_q.exp - 10'sd127;
      prod_q <= ua_q.man * ub_q.man;
      r_q    <= r_d;
    end
  end

  always_comb begin
    if (prod_q[47]) begin
      sig   = {prod_q[47:22], |prod_q[21:0]};
      exp_n = exp_q + 10'sd1;
    end else begin
      sig   = {prod_q[46:21], |prod_q[20:0]};
      exp_n = exp_q;
    end
    if (nan_q) begin
      r_d = QNAN_BITS;
    end else if (inf_q) begin
      r_d = {sign_q, 8'hFF, 23'h0};
    end else if (zero_q) begin
      r_d = {sign_q, 31'h0};
    end else begin
      r_d = round_pack(sign_q, exp_n, sig);
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

>>> src/fva_add.sv
// ----------------------------------------------------------------------------
// fva_add: four-stage binary32 adder and subtractor
// Align, add, normalize by leading-zero count, then round.
// ----------------------------------------------------------------------------
`default_nettype none

module fva_add
  import fva_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  input  wire logic        sub_i,
  output logic [31:0]      r_o
);

  logic [31:0] bb, big, sml;
  logic [7:0]  eb, es, shamt;
  logic [26:0] ms, al, mask;
  logic        nan_a, nan_b, inf_a, inf_b;

  logic        sign1_q, zs1_q, sub1_q, nan1_q, inf1_q, isg1_q;
  logic [7:0]  e1_q;
  logic [26:0] mb1_q, al1_q;

  logic        sign2_q, zs2_q, nan2_q, inf2_q, isg2_q;
  logic [7:0]  e2_q;
  logic [27:0] sum2_q;

  logic        sign3_q, zs3_q, nan3_q, inf3_q, isg3_q, zero3_q;
  logic signed [9:0] ex3_q, ex3_d;
  logic [26:0] sig3_q, sig3_d;
  logic [5:0]  lz;

  logic [31:0] r_q, r_d;

  always_comb begin
    bb    = {b_i[31] ^ sub_i, b_i[30:0]};
    big   = (bb[30:0] > a_i[30:0]) ? bb : a_i;
    sml   = (bb[30:0] > a_i[30:0]) ? a_i : bb;
    eb    = (big[30:23] == 8'h00) ? 8'd1 : big[30:23];
    es    = (sml[30:23] == 8'h00) ? 8'd1 : sml[30:23];
    shamt = eb - es;
    ms    = {sml[30:23] != 8'h00, sml[22:0], 3'b000};
    mask  = '0;
    if (shamt >= 8'd27) begin
      al = {26'h0, |ms};
    end else begin
      mask  = (27'd1 << shamt[4:0]) - 27'd1;
      al    = ms >> shamt[4:0];
      al[0] = al[0] | (|(ms & mask));
    end
    nan_a = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'h0);
    nan_b = (bb[30:23] == 8'hFF) && (bb[22:0] != 23'h0);
    inf_a = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'h0);
    inf_b = (bb[30:23] == 8'hFF) && (bb[22:0] == 23'h0);
  end

  always_comb begin
    lz = lzc32({sum2_q[26:0], 5'h0});
    if (sum2_q[27]) begin
      sig3_d = {sum2_q[27:2], sum2_q[1] | sum2_q[0]};
      ex3_d  = $signed({2'b00, e2_q}) + 10'sd1;
    end else begin
      sig3_d = sum2_q[26:0] << lz[4:0];
      ex3_d  = $signed({2'b00, e2_q}) - $signed({4'b0000, lz});
    end
  end

  always_comb begin
    if (nan3_q) begin
      r_d = QNAN_BITS;
    end else if (inf3_q) begin
      r_d = {isg3_q, 8'hFF, 23'h0};
    end else if (zero3_q) begin
      r_d = {zs3_q, 31'h0};
    end else begin
      r_d = round_pack(sign3_q, ex3_q, sig3_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sign1_q <= big[31];
      zs1_q   <= a_i[31] & bb[31];
      sub1_q  <= a_i[31] ^ bb[31];
      nan1_q  <= nan_a | nan_b | (inf_a & inf_b & (a_i[31] != bb[31]));
      inf1_q  <= inf_a | inf_b;
      isg1_q  <= inf_a ? a_i[31] : bb[31];
      e1_q    <= eb;
      mb1_q   <= {big[30:23] != 8'h00, big[22:0], 3'b000};
      al1_q   <= al;

      sign2_q <= sign1_q;
      zs2_q   <= zs1_q;
      nan2_q  <= nan1_q;
      inf2_q  <= inf1_q;
      isg2_q  <= isg1_q;
      e2_q    <= e1_q;
      sum2_q  <= sub1_q ? ({1'b0, mb1_q} - {1'b0, al1_q}) : ({1'b0, mb1_q} + {1'b0, al1_q});

      sign3_q <= sign2_q;
      zs3_q   <= zs2_q;
      nan3_q  <= nan2_q;
      inf3_q  <= inf2_q;
      isg3_q  <= isg2_q;
      zero3_q <= (sum2_q == 28'h0);
      ex3_q   <= ex3_d;
      sig3_q  <= sig3_d;

      r_q     <= r_d;
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

>>> src/fva_div.sv
// ----------------------------------------------------------------------------
// fva_div: pipelined binary32 divider
// Restoring division, a fixed number of quotient bits per stage, then round.
// ----------------------------------------------------------------------------
`default_nettype none

module fva_div
  import fva_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic [31:0]      r_o
);

  typedef struct packed {
    logic              sign;
    logic signed [9:0] exp;
    logic              nan;
    logic              inf;
    logic              zero;
  } dctl_t;

  unp_t        ua_q, ub_q;
  logic        lt;
  dctl_t       ctl_q  [DIV_STAGES+1];
  logic [24:0] rem_q  [DIV_STAGES+1];
  logic [26:0] quo_q  [DIV_STAGES+1];
  logic [23:0] dvs_q  [DIV_STAGES+1];
  logic [24:0] rem_d  [DIV_STAGES];
  logic [26:0] quo_d  [DIV_STAGES];
  logic [26:0] sig;
  logic [31:0] r_q, r_d;

  assign lt = ua_q.man < ub_q.man;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q          <= unpack(a_i);
      ub_q          <= unpack(b_i);
      ctl_q[0].sign <= ua_q.sign ^ ub_q.sign;
      ctl_q[0].exp  <= ua_q.exp - ub_q.exp + 10'sd127 - $signed({9'h0, lt});
      ctl_q[0].nan  <= ua_q.nan | ub_q.nan | (ua_q.zero & ub_q.zero) | (ua_q.inf & ub_q.inf);
      ctl_q[0].inf  <= ua_q.inf | ub_q.zero;
      ctl_q[0].zero <= ua_q.zero | ub_q.inf;
      rem_q[0]      <= lt ? {ua_q.man, 1'b0} : {1'b0, ua_q.man};
      quo_q[0]      <= '0;
      dvs_q[0]      <= ub_q.man;
      r_q           <= r_d;
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_step
    always_comb begin
      logic [24:0] r;
      logic [26:0] q;
      r = rem_q[s];
      q = quo_q[s];
      for (int j = 0; j < DIV_PER_STAGE; j++) begin
        if (r >= {1'b0, dvs_q[s]}) begin
          r = r - {1'b0, dvs_q[s]};
          q = {q[25:0], 1'b1};
        end else begin
          q = {q[25:0], 1'b0};
        end
        r = {r[23:0], 1'b0};
      end
      rem_d[s] = r;
      quo_d[s] = q;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ctl_q[s+1] <= ctl_q[s];
        rem_q[s+1] <= rem_d[s];
        quo_q[s+1] <= quo_d[s];
        dvs_q[s+1] <= dvs_q[s];
      end
    end
  end

  always_comb begin
    sig = {quo_q[DIV_STAGES][26:1], quo_q[DIV_STAGES][0] | (rem_q[DIV_STAGES] != 25'h0)};
    if (ctl_q[DIV_STAGES].nan) begin
      r_d = QNAN_BITS;
    end else if (ctl_q[DIV_STAGES].inf) begin
      r_d = {ctl_q[DIV_STAGES].sign, 8'hFF, 23'h0};
    end else if (ctl_q[DIV_STAGES].zero) begin
      r_d = {ctl_q[DIV_STAGES].sign, 31'h0};
    end else begin
      r_d = round_pack(ctl_q[DIV_STAGES].sign, ctl_q[DIV_STAGES].exp, sig);
    end
  end

  assign r_o = r_q;

endmodule

`default_nettype wire

>>> src/fva_merge.sv
// ----------------------------------------------------------------------------
// fva_merge: combines lane results into the response
// Dot-product reduction, comparisons and logic, the int32 bitwise path and
// the final selection, all aligned to the same pipeline depth.
// ----------------------------------------------------------------------------
`default_nettype none

module fva_merge
  import fva_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire req_t             req_i,
  input  wire logic [2:0][31:0] mul_i,
  input  wire logic [2:0][31:0] add_i,
  input  wire logic [31:0]      div_i,
  output rsp_t                  rsp_o
);

  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hFF) && (f[22:0] != 23'h0);
  endfunction

  function automatic logic is_zero(input logic [31:0] f);
    return f[30:0] == 31'h0;
  endfunction

  function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && ((a == b) || (is_zero(a) && is_zero(b)));
  endfunction

  function automatic logic f_lt(input logic [31:0] a, input logic [31:0] b);
    logic r;
    if (is_nan(a) || is_nan(b) || (is_zero(a) && is_zero(b))) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  // Truncation toward zero with saturation; NaN gives zero.
  function automatic logic [31:0] trunc_i32(input logic [31:0] f);
    logic [31:0] m;
    logic [31:0] r;
    m = '0;
    if (is_nan(f)) begin
      r = '0;
    end else if (f[30:23] >= 8'd158) begin
      r = f[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else if (f[30:23] < 8'd127) begin
      r = '0;
    end else begin
      m = {1'b1, f[22:0], 8'h00} >> 5'(8'd158 - f[30:23]);
      r = f[31] ? (32'h0 - m) : m;
    end
    return r;
  endfunction

  logic [4:0]  op_q    [PIPE_DEPTH];
  logic        truth_d;
  logic        truth_q [4];
  logic [31:0] int_q, int_d;
  logic        ineg;
  logic [31:0] imag, inorm;
  logic [5:0]  ilz;
  logic        isg_q, izero_q;
  logic signed [9:0] iex_q;
  logic [26:0] isig_q;
  logic [31:0] ir3_q, ir4_q;
  logic [31:0] mz_q    [4];
  logic [2:0][31:0] mul_q;
  logic [31:0] dot_s1, dot_s2, dot_q;
  rsp_t        early_d;
  rsp_t        er_q    [8];

  always_comb begin
    unique case (req_i.req_type)
      OP_EQF:    truth_d = f_eq(req_i.a_x, req_i.b_x);
      OP_EQV:    truth_d = f_eq(req_i.a_x, req_i.b_x) && f_eq(req_i.a_y, req_i.b_y)
                           && f_eq(req_i.a_z, req_i.b_z);
      OP_EQBITS: truth_d = req_i.a_x == req_i.b_x;
      OP_NEF:    truth_d = !f_eq(req_i.a_x, req_i.b_x);
      OP_NEV:    truth_d = !f_eq(req_i.a_x, req_i.b_x) || !f_eq(req_i.a_y, req_i.b_y)
                           || !f_eq(req_i.a_z, req_i.b_z);
      OP_NEBITS: truth_d = req_i.a_x != req_i.b_x;
      OP_LE:     truth_d = f_lt(req_i.a_x, req_i.b_x) || f_eq(req_i.a_x, req_i.b_x);
      OP_GE:     truth_d = f_lt(req_i.b_x, req_i.a_x) || f_eq(req_i.a_x, req_i.b_x);
      OP_LT:     truth_d = f_lt(req_i.a_x, req_i.b_x);
      OP_GT:     truth_d = f_lt(req_i.b_x, req_i.a_x);
      OP_NOTF:   truth_d = is_zero(req_i.a_x);
      OP_NOTV:   truth_d = is_zero(req_i.a_x) && is_zero(req_i.a_y) && is_zero(req_i.a_z);
      OP_AND:    truth_d = !is_zero(req_i.a_x) && !is_zero(req_i.b_x);
      OP_OR:     truth_d = !is_zero(req_i.a_x) || !is_zero(req_i.b_x);
      default:   truth_d = 1'b0;
    endcase
    if (req_i.req_type == OP_BITOR) begin
      int_d = trunc_i32(req_i.a_x) | trunc_i32(req_i.b_x);
    end else begin
      int_d = trunc_i32(req_i.a_x) & trunc_i32(req_i.b_x);
    end
  end

  // Signed int32 back to binary32.
  always_comb begin
    ineg  = int_q[31];
    imag  = ineg ? (32'h0 - int_q) : int_q;
    ilz   = lzc32(imag);
    inorm = imag << ilz[4:0];
  end

  fva_add u_dot0 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (mul_i[0]),
    .b_i   (mul_i[1]),
    .sub_i (1'b0),
    .r_o   (dot_s1)
  );

  fva_add u_dot1 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (dot_s1),
    .b_i   (mz_q[3]),
    .sub_i (1'b0),
    .r_o   (dot_s2)
  );

  // The multiplier finishes one stage ahead of the adder, so its lanes
  // are held in one more register, mul_q, before the selection.
  always_comb begin
    early_d = '0;
    case (op_q[3]) inside
      OP_MULF: early_d.r_x = mul_q[0];
      OP_FV, OP_VF: begin
        early_d.r_x = mul_q[0];
        early_d.r_y = mul_q[1];
        early_d.r_z = mul_q[2];
      end
      OP_ADDF, OP_SUBF: early_d.r_x = add_i[0];
      OP_ADDV, OP_SUBV: begin
        early_d.r_x = add_i[0];
        early_d.r_y = add_i[1];
        early_d.r_z = add_i[2];
      end
      OP_BITAND, OP_BITOR: early_d.r_x = ir4_q;
      OP_EQF, OP_EQV, OP_EQBITS, OP_NEF, OP_NEV, OP_NEBITS, OP_LE, OP_GE,
      OP_LT, OP_GT, OP_NOTF, OP_NOTV, OP_AND, OP_OR:
        early_d.r_x = truth_q[3] ? ONE_BITS : 32'h0;
      default: early_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q[0]    <= req_i.req_type;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        op_q[k] <= op_q[k-1];
      end
      truth_q[0] <= truth_d;
      for (int k = 1; k < 4; k++) begin
        truth_q[k] <= truth_q[k-1];
        mz_q[k]    <= mz_q[k-1];
      end
      mz_q[0]    <= mul_i[2];
      mul_q      <= mul_i;
      int_q      <= int_d;
      isg_q      <= ineg;
      izero_q    <= (imag == 32'h0);
      iex_q      <= 10'sd158 - $signed({4'b0000, ilz});
      isig_q     <= {inorm[31:6], |inorm[5:0]};
      ir3_q      <= izero_q ? 32'h0 : round_pack(isg_q, iex_q, isig_q);
      ir4_q      <= ir3_q;
      dot_q      <= dot_s2;
      er_q[0]    <= early_d;
      for (int k = 1; k < 8; k++) begin
        er_q[k] <= er_q[k-1];
      end
    end
  end

  always_comb begin
    rsp_o = er_q[7];
    case (op_q[PIPE_DEPTH-1])
      OP_DOT:  rsp_o = '{r_x: dot_q, r_y: 32'h0, r_z: 32'h0};
      OP_DIVF: rsp_o = '{r_x: div_i, r_y: 32'h0, r_z: 32'h0};
      default: rsp_o = er_q[7];
    endcase
  end

endmodule

`default_nettype wire

>>> src/fp32_vec3_alu.sv
// ----------------------------------------------------------------------------
// fp32_vec3_alu: three-lane binary32 arithmetic unit
// Scalar and vector float arithmetic, dot product, comparisons and logic.
// ----------------------------------------------------------------------------
// Usage:
//   A request (in_req_i) carries an operation code and two three-lane
//   operands. It is taken at a rising edge where in_valid_i is high and
//   in_stall_o is low. Each request yields exactly one response on
//   out_rsp_o, taken where out_valid_o is high and out_stall_i is low.
//   Scalar results sit in lane x with zero in lanes y and z.
//   The unit takes one request every cycle while in_stall_o is low. A
//   response passes through twelve pipeline stages, the first loaded at
//   the taking edge, their depth set by the division path (unpack,
//   prescale, nine stages of three quotient bits, round), then through
//   the output register. Shorter operations are delayed to the same
//   depth so responses leave in request order.
//   Reset clears the stage valid bits, the output valid flag and the skid
//   flag; no request is in flight afterwards.
//   When the receiver stalls, the waiting response holds, the pipeline
//   keeps moving until one more response lands in the skid slot, and only
//   then is in_stall_o raised and the whole pipeline frozen.
// ----------------------------------------------------------------------------
`default_nettype none

module fp32_vec3_alu
  import fva_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_req_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_rsp_o
);

  logic                  adv;
  logic [PIPE_DEPTH-1:0] vld_q;
  logic [2:0][31:0]      a_vec, b_vec, mul_a, mul_b, mul_r, add_r;
  logic                  sub_op;
  logic [31:0]           div_r;
  rsp_t                  pipe_rsp;
  logic                  pipe_done;

  logic out_valid_q, out_valid_d;
  logic skid_full_q, skid_full_d;
  rsp_t out_rsp_q, out_rsp_d;
  rsp_t skid_q, skid_d;

  // The whole pipeline moves together; it freezes only once the skid slot
  // is holding a response behind a stalled output register.
  assign adv        = !skid_full_q;
  assign in_stall_o = skid_full_q;

  assign a_vec  = {in_req_i.a_z, in_req_i.a_y, in_req_i.a_x};
  assign b_vec  = {in_req_i.b_z, in_req_i.b_y, in_req_i.b_x};
  assign sub_op = (in_req_i.req_type == OP_SUBF) || (in_req_i.req_type == OP_SUBV);

  // Lanes: one multiplier and one adder per vector element. The scalar
  // times vector forms broadcast lane x of the scalar operand.
  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign mul_a[i] = (in_req_i.req_type == OP_FV) ? in_req_i.a_x : a_vec[i];
    assign mul_b[i] = (in_req_i.req_type == OP_VF) ? in_req_i.b_x : b_vec[i];

    fva_mul u_mul (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (mul_a[i]),
      .b_i   (mul_b[i]),
      .r_o   (mul_r[i])
    );

    fva_add u_add (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (a_vec[i]),
      .b_i   (b_vec[i]),
      .sub_i (sub_op),
      .r_o   (add_r[i])
    );
  end

  fva_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .a_i   (in_req_i.a_x),
    .b_i   (in_req_i.b_x),
    .r_o   (div_r)
  );

  fva_merge u_merge (
    .clk_i (clk_i),
    .en_i  (adv),
    .req_i (in_req_i),
    .mul_i (mul_r),
    .add_i (add_r),
    .div_i (div_r),
    .rsp_o (pipe_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], in_valid_i};
    end
  end

  assign pipe_done = adv && vld_q[PIPE_DEPTH-1];

  // Output register with a one-entry skid slot behind it.
  always_comb begin
    out_valid_d = out_valid_q;
    skid_full_d = skid_full_q;
    out_rsp_d   = out_rsp_q;
    skid_d      = skid_q;
    if (skid_full_q) begin
      if (!out_stall_i) begin
        out_rsp_d   = skid_q;
        skid_full_d = 1'b0;
      end
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_d = pipe_done;
      if (pipe_done) begin
        out_rsp_d = pipe_rsp;
      end
    end else if (pipe_done) begin
      skid_full_d = 1'b1;
      skid_d      = pipe_rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_full_q <= skid_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rsp_q <= out_rsp_d;
    skid_q    <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // The skid slot is only ever filled behind a waiting response.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |-> out_valid_q)
    else $error("skid slot full without a response in the output register");

  a_skid_fill_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_full_q) |-> $past(out_valid_q && out_stall_i && vld_q[PIPE_DEPTH-1]))
    else $error("skid slot filled without a stalled output and a finished request");

  a_stalled_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled response dropped");

  a_freeze_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full_q |=> $stable(vld_q) || !$past(skid_full_q))
    else $error("pipeline moved while frozen");

endmodule

`default_nettype wire
